>>> src/pcpg_pkg.sv
// Package: payload types, controller command and status types, and widths.
package pcpg_pkg;

  typedef struct packed {
    logic        func;
    logic [3:0]  slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] charge_strength;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] potential;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic signed [47:0] grad_z;
    logic               singular;
  } out_beat_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;  // clear accumulators
  localparam logic [3:0] OP_FETCH  = 4'd2;  // registered read of one slot
  localparam logic [3:0] OP_DIFF   = 4'd3;  // differences and magnitudes
  localparam logic [3:0] OP_SQ     = 4'd4;  // one squared component per cycle
  localparam logic [3:0] OP_SQRT   = 4'd5;  // one root bit per cycle
  localparam logic [3:0] OP_LDDIV  = 4'd6;  // load dividend for one division
  localparam logic [3:0] OP_DIV    = 4'd7;  // one quotient bit per cycle
  localparam logic [3:0] OP_ACC    = 4'd8;  // clamp term and add to sum
  localparam logic [3:0] OP_MUL    = 4'd9;  // |charge| times |d component| product

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] comp;     // component index 0..2, or 3 for the potential
    logic [6:0] bitn;     // bit index for iterative steps
  } dp_cmd_t;

  typedef struct packed {
    logic zero_dist;      // D is zero for the current charge
  } dp_stat_t;

  localparam int SQRT_BITS = 43;
  localparam int DIV_BITS  = 128;

endpackage

>>> src/point_charge_potential_and_gradient_top.sv
// Top level: point-charge potential and gradient by direct summation.
//
//  Channel  | Signals                         | Beat contents
//  ---------+---------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data     | load slot or evaluate point
//  output   | out_valid, out_stall, out_data  | potential, gradient, singular
//  config   | cfg_we, cfg_data                | charge_count
//
// An evaluate beat runs each active charge through one shared root unit and
// one shared bit-serial divider (ten divisions: one for the potential and
// three in a row for each gradient component); the sums then go into the
// output register. Reset sets charge_count to 12 and idles the controller;
// the table is not cleared. The result sits in an output register, so an
// output stall holds only that register; the input is stalled during an
// evaluation and while that register is still full.
module point_charge_potential_and_gradient_top #(
  parameter int MAX_CHARGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcpg_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcpg_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data
);

  localparam int IW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;

  logic [4:0]          count;
  logic                load_en, latch_point, done, done_sing;
  logic [IW-1:0]       idx;
  pcpg_pkg::dp_cmd_t   cmd;
  pcpg_pkg::dp_stat_t  stat;
  pcpg_pkg::out_beat_t result;

  always_ff @(posedge clk) begin
    if (rst) count <= 5'd12;
    else if (cfg_we) count <= cfg_data;
  end

  pcpg_ctrl #(.MAX_CHARGES(MAX_CHARGES), .IW(IW)) u_ctrl (
    .clk, .rst, .in_valid, .in_func(in_data.func), .count,
    .out_busy(out_valid), .stat, .in_stall, .load_en, .latch_point,
    .idx, .cmd, .done, .done_sing
  );

  pcpg_dp #(.MAX_CHARGES(MAX_CHARGES), .IW(IW)) u_dp (
    .clk, .in_data, .load_en, .latch_point, .idx, .cmd, .done_sing,
    .stat, .result
  );

  // The output register holds a finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (done) out_data <= result;
  end

endmodule

>>> src/pcpg_ctrl.sv
// Controller: sequences load, evaluation and result hand-off.
module pcpg_ctrl #(
  parameter int MAX_CHARGES = 16,
  parameter int IW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  input  logic [4:0]        count,
  input  logic              out_busy,
  input  pcpg_pkg::dp_stat_t stat,
  output logic              in_stall,
  output logic              load_en,
  output logic              latch_point,
  output logic [IW-1:0]     idx,
  output pcpg_pkg::dp_cmd_t cmd,
  output logic              done,
  output logic              done_sing
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NEXT  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_LDDIV = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    state, state_next;
  logic [IW:0]   cnt, cnt_next;
  logic [1:0]    comp, comp_next;
  logic [1:0]    pass, pass_next;
  logic [6:0]    bitn, bitn_next;
  logic [IW:0]   n_act;
  logic          sing, sing_next;

  always_comb begin
    if (32'(count) > MAX_CHARGES) n_act = (IW+1)'(MAX_CHARGES);
    else n_act = (IW+1)'(count);
  end

  assign in_stall    = (state != S_IDLE) || out_busy;
  assign load_en     = in_valid && !in_stall && (in_func == pcpg_pkg::FUNC_LOAD);
  assign latch_point = in_valid && !in_stall && (in_func == pcpg_pkg::FUNC_EVAL);
  assign idx         = cnt[IW-1:0];
  assign done        = (state == S_DONE);
  assign done_sing   = sing;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    pass_next  = pass;
    bitn_next  = bitn;
    sing_next  = sing;
    cmd        = '{op: pcpg_pkg::OP_NONE, comp: comp, bitn: bitn};
    unique case (state)
      S_IDLE: begin
        if (latch_point) begin
          cmd.op     = pcpg_pkg::OP_CLEAR;
          cnt_next   = '0;
          sing_next  = 1'b0;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (cnt >= n_act) state_next = S_DONE;
        else begin
          cmd.op     = pcpg_pkg::OP_FETCH;
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_DIFF;
      S_DIFF: begin
        cmd.op     = pcpg_pkg::OP_DIFF;
        comp_next  = 2'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = pcpg_pkg::OP_SQ;
        if (comp == 2'd2) state_next = S_CHK;
        comp_next = comp + 2'd1;
      end
      S_CHK: begin
        if (stat.zero_dist) begin
          sing_next  = 1'b1;
          state_next = S_DONE;
        end else begin
          bitn_next  = 7'(pcpg_pkg::SQRT_BITS - 1);
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = pcpg_pkg::OP_SQRT;
        bitn_next = bitn - 7'd1;
        if (bitn == 7'd0) begin
          comp_next  = 2'd3;
          state_next = S_LDDIV;
        end
      end
      S_MUL: begin
        cmd.op     = pcpg_pkg::OP_MUL;
        state_next = S_LDDIV;
      end
      S_LDDIV: begin
        cmd.op     = pcpg_pkg::OP_LDDIV;
        pass_next  = 2'd0;
        bitn_next  = 7'(pcpg_pkg::DIV_BITS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = pcpg_pkg::OP_DIV;
        bitn_next = bitn - 7'd1;
        if (bitn == 7'd0) begin
          if (comp != 2'd3 && pass != 2'd2) begin
            pass_next = pass + 2'd1;
            bitn_next = 7'(pcpg_pkg::DIV_BITS - 1);
          end else state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = pcpg_pkg::OP_ACC;
        if (comp == 2'd2) begin
          cnt_next   = cnt + (IW+1)'(1);
          state_next = S_NEXT;
        end else begin
          comp_next  = (comp == 2'd3) ? 2'd0 : comp + 2'd1;
          state_next = S_MUL;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      comp  <= '0;
      pass  <= '0;
      bitn  <= '0;
      sing  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      pass  <= pass_next;
      bitn  <= bitn_next;
      sing  <= sing_next;
    end
  end

endmodule

>>> src/pcpg_dp.sv
// Datapath: charge table, distance, root, divider and accumulators.
module pcpg_dp #(
  parameter int MAX_CHARGES = 16,
  parameter int IW = 5
) (
  input  logic               clk,
  input  pcpg_pkg::in_beat_t in_data,
  input  logic               load_en,
  input  logic               latch_point,
  input  logic [IW-1:0]      idx,
  input  pcpg_pkg::dp_cmd_t  cmd,
  input  logic               done_sing,
  output pcpg_pkg::dp_stat_t stat,
  output pcpg_pkg::out_beat_t result
);

  localparam logic [63:0] TERM_LIM = 64'd1 << 52;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 47);

  logic [127:0] mem [MAX_CHARGES];
  logic [127:0] rd;
  logic signed [31:0] px, py, pz;
  logic [32:0] ad [3];
  logic        dneg [3];
  logic [31:0] aq;
  logic        qneg;
  logic [66:0] dsum;
  logic [42:0] root;
  logic [85:0] rsq;
  logic [127:0] dvd, quo;
  logic [42:0]  rem;
  logic [63:0]  prod;
  logic signed [63:0] acc [4];

  // The stored slot is addressed by the low bits of the slot field.
  logic [IW-1:0] wslot;
  assign wslot = IW'(in_data.slot);

  always_ff @(posedge clk) begin
    if (load_en && (32'(in_data.slot) < MAX_CHARGES))
      mem[wslot] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z,
                     in_data.charge_strength};
    if (cmd.op == pcpg_pkg::OP_FETCH) rd <= mem[idx];
  end

  logic signed [32:0] dd [3];
  always_comb begin
    dd[0] = 33'(px) - 33'(signed'(rd[127:96]));
    dd[1] = 33'(py) - 33'(signed'(rd[95:64]));
    dd[2] = 33'(pz) - 33'(signed'(rd[63:32]));
  end

  // Root trial: compare (root|bit)^2 with D*2^16, one bit a cycle. The square
  // of the trial is built from the square of the root so far by shifts and adds.
  logic [42:0]  trial;
  logic [85:0]  tsq;
  assign trial = root | (43'd1 << cmd.bitn);
  assign tsq   = rsq + (86'(root) << (cmd.bitn + 7'd1)) + (86'd1 << {cmd.bitn, 1'b0});

  // Division step over a 128-bit dividend, divisor root.
  logic [43:0] rsh;
  assign rsh = {rem, dvd[cmd.bitn]};

  // The final division quotient lives in dvd after the last bit.
  logic [127:0] quo_fin;
  always_comb begin
    quo_fin = dvd;
  end

  logic [63:0] qmag;
  logic        tneg;
  logic signed [63:0] term;
  always_comb begin
    qmag = (quo_fin[127:64] != 0 || quo_fin[63:0] > TERM_LIM) ? TERM_LIM : quo_fin[63:0];
    tneg = (cmd.comp == 2'd3) ? qneg : (qneg == dneg[cmd.comp]);
    term = tneg ? -signed'(qmag) : signed'(qmag);
  end

  assign stat.zero_dist = (dsum == '0);

  always_ff @(posedge clk) begin
    if (latch_point) begin
      px <= in_data.pos_x;
      py <= in_data.pos_y;
      pz <= in_data.pos_z;
    end
    unique case (cmd.op)
      pcpg_pkg::OP_CLEAR: begin
        for (int k = 0; k < 4; k++) acc[k] <= '0;
      end
      pcpg_pkg::OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dneg[k] <= dd[k][32];
          ad[k]   <= dd[k][32] ? 33'(-dd[k]) : 33'(dd[k]);
        end
        qneg <= rd[31];
        aq   <= rd[31] ? 32'(-rd[31:0]) : rd[31:0];
        dsum <= '0;
        root <= '0;
        rsq  <= '0;
      end
      pcpg_pkg::OP_SQ: dsum <= dsum + 67'(ad[cmd.comp] * ad[cmd.comp]);
      pcpg_pkg::OP_SQRT: begin
        if (tsq <= {3'd0, dsum, 16'd0}) begin
          root <= trial;
          rsq  <= tsq;
        end
      end
      pcpg_pkg::OP_MUL: prod <= 64'(aq * ad[cmd.comp]);
      pcpg_pkg::OP_LDDIV: begin
        if (cmd.comp == 2'd3) dvd <= {64'd0, aq, 32'd0};
        else dvd <= {prod, 64'd0};
        rem <= '0;
        quo <= '0;
      end
      pcpg_pkg::OP_DIV: begin
        if (cmd.bitn == 7'd0) begin
          // Chain the next pass on the finished quotient.
          dvd <= (rsh >= {1'b0, root}) ? (quo | 128'd1) : quo;
          rem <= '0;
          quo <= '0;
        end else if (rsh >= {1'b0, root}) begin
          rem <= 43'(rsh - {1'b0, root});
          quo <= quo | (128'd1 << cmd.bitn);
        end else rem <= rsh[42:0];
      end
      pcpg_pkg::OP_ACC: begin
        if (cmd.comp == 2'd3) acc[0] <= acc[0] + term;
        else acc[cmd.comp + 2'd1] <= acc[cmd.comp + 2'd1] + term;
      end
      default: ;
    endcase
  end

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > OUT_MAX) return OUT_MAX[47:0];
    if (v < OUT_MIN) return OUT_MIN[47:0];
    return v[47:0];
  endfunction

  always_comb begin
    if (done_sing) begin
      result.potential = qneg ? OUT_MIN[47:0] : OUT_MAX[47:0];
      result.grad_x    = '0;
      result.grad_y    = '0;
      result.grad_z    = '0;
      result.singular  = 1'b1;
    end else begin
      result.potential = sat48(acc[0]);
      result.grad_x    = sat48(acc[1]);
      result.grad_y    = sat48(acc[2]);
      result.grad_z    = sat48(acc[3]);
      result.singular  = 1'b0;
    end
  end

endmodule

>>> dv/pcpg_field_checker.sv
// Checker: watches the channels, predicts potential and gradient, compares each result beat.
`timescale 1ns / 100ps

module pcpg_field_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pcpg_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pcpg_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  output int                  fail_count,
  output int                  fields_waiting,
  output int                  results_seen
);

  localparam longint TERM_CAP = longint'(1) << 52;
  localparam longint OUT_HI   = (longint'(1) << 47) - 1;
  localparam longint OUT_LO   = -(longint'(1) << 47);

  logic [31:0] tab_x [16];
  logic [31:0] tab_y [16];
  logic [31:0] tab_z [16];
  logic [31:0] tab_q [16];
  logic [4:0]  active_count;
  pcpg_pkg::out_beat_t field_queue[$];

  function automatic logic signed [47:0] sat48(longint v);
    if (v > OUT_HI) return OUT_HI[47:0];
    if (v < OUT_LO) return OUT_LO[47:0];
    return v[47:0];
  endfunction

  function automatic longint clamp_term(logic [127:0] mag, logic neg);
    longint m;
    m = (mag > 128'(TERM_CAP)) ? TERM_CAP : longint'(mag[63:0]);
    return neg ? -m : m;
  endfunction

  // Direct sum over the active slots; the first coinciding charge ends the sum.
  function automatic pcpg_pkg::out_beat_t field_at_point(logic signed [31:0] px,
                                                         logic signed [31:0] py,
                                                         logic signed [31:0] pz);
    pcpg_pkg::out_beat_t r;
    longint       pot, gr[3], d[3], q;
    logic [127:0] ad[3], dist2, e, root, c, aq, t;
    int           n;
    pot = 0;
    gr = '{0, 0, 0};
    n = (active_count > 16) ? 16 : int'(active_count);
    for (int i = 0; i < n; i++) begin
      q = longint'($signed(tab_q[i]));
      aq = (q < 0) ? 128'(-q) : 128'(q);
      d[0] = longint'(px) - longint'($signed(tab_x[i]));
      d[1] = longint'(py) - longint'($signed(tab_y[i]));
      d[2] = longint'(pz) - longint'($signed(tab_z[i]));
      dist2 = 0;
      for (int j = 0; j < 3; j++) begin
        ad[j] = (d[j] < 0) ? 128'(-d[j]) : 128'(d[j]);
        dist2 = dist2 + ad[j] * ad[j];
      end
      if (dist2 == 0) begin
        r.potential = (q < 0) ? OUT_LO[47:0] : OUT_HI[47:0];
        r.grad_x = '0;
        r.grad_y = '0;
        r.grad_z = '0;
        r.singular = 1'b1;
        return r;
      end
      // Root of D scaled by 2^16 gives |d| in units of 2^-8.
      e = dist2 << 16;
      root = 0;
      for (int b = 42; b >= 0; b--) begin
        c = root | (128'(1) << b);
        if (c * c <= e) root = c;
      end
      t = (aq << 32) / root;
      pot += clamp_term(t, q < 0);
      for (int j = 0; j < 3; j++) begin
        t = (aq * ad[j]) << 64;
        t = t / root;
        t = t / root;
        t = t / root;
        gr[j] += clamp_term(t, (q < 0) == (d[j] < 0));
      end
    end
    r.potential = sat48(pot);
    r.grad_x = sat48(gr[0]);
    r.grad_y = sat48(gr[1]);
    r.grad_z = sat48(gr[2]);
    r.singular = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, field, got, want);
    fail_count++;
  endtask

  assign fields_waiting = field_queue.size();

  initial begin
    fail_count = 0;
    results_seen = 0;
    active_count = 5'd12;
  end

  always @(posedge clk) begin
    pcpg_pkg::out_beat_t want;
    if (rst) begin
      active_count <= 5'd12;
    end else begin
      if (cfg_we) active_count <= cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.func == pcpg_pkg::FUNC_LOAD) begin
          tab_x[in_data.slot] = in_data.pos_x;
          tab_y[in_data.slot] = in_data.pos_y;
          tab_z[in_data.slot] = in_data.pos_z;
          tab_q[in_data.slot] = in_data.charge_strength;
        end else begin
          field_queue.push_back(field_at_point(in_data.pos_x, in_data.pos_y, in_data.pos_z));
        end
      end
      if (out_valid && !out_stall) begin
        if (field_queue.size() == 0) begin
          report_mismatch("beat with nothing expected", 48'd0, 48'd0);
        end else begin
          want = field_queue.pop_front();
          if (out_data.potential !== want.potential)
            report_mismatch("potential", out_data.potential, want.potential);
          if (out_data.grad_x !== want.grad_x)
            report_mismatch("grad_x", out_data.grad_x, want.grad_x);
          if (out_data.grad_y !== want.grad_y)
            report_mismatch("grad_y", out_data.grad_y, want.grad_y);
          if (out_data.grad_z !== want.grad_z)
            report_mismatch("grad_z", out_data.grad_z, want.grad_z);
          if (out_data.singular !== want.singular)
            report_mismatch("singular", 48'(out_data.singular), 48'(want.singular));
        end
        results_seen++;
      end
    end
  end

endmodule

>>> dv/tb_point_charge_potential_and_gradient_top.sv
// Testbench top: drives charge loads and evaluation points, gives the verdict.
`timescale 1ns / 100ps

module tb_point_charge_potential_and_gradient_top;

  // The slowest evaluation is one with sixteen active charges; the limit
  // leaves ample room over a worst-case run.
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int SETTLE      = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pcpg_pkg::in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pcpg_pkg::out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;

  int fail_count, fields_waiting, results_seen;
  int cycle_count = 0;
  int beats_sent = 0;
  int eval_sent = 0;
  bit idling_on = 1'b1;
  int stall_left = 0;
  int run_left = 0;

  // Copy of the loaded positions, used only to aim points at or near charges.
  logic [31:0] aim_x [16];
  logic [31:0] aim_y [16];
  logic [31:0] aim_z [16];
  logic [4:0]  cur_count = 5'd12;

  point_charge_potential_and_gradient_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  pcpg_field_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .fields_waiting(fields_waiting), .results_seen(results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, fields_waiting);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts between runs of free
  // flow, so stalls land on every phase of the output register.
  always @(posedge clk) begin
    if (!idling_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_stall <= 1'b1;
    end else begin
      run_left <= $urandom_range(1, 40);
      out_stall <= 1'b0;
    end
  end

  // Presents one beat, with an optional idle burst first, and returns just
  // after the edge at which it was taken. Stall is looked at on the falling
  // edge, where it is settled.
  task automatic send_beat(pcpg_pkg::in_beat_t b);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    if (b.func == pcpg_pkg::FUNC_EVAL) begin
      eval_sent++;
    end else begin
      aim_x[b.slot] = b.pos_x;
      aim_y[b.slot] = b.pos_y;
      aim_z[b.slot] = b.pos_z;
    end
  endtask

  // Holds the sender back until every expected result has come, then lets
  // the block settle; the sender is left idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (fields_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_charge_count(logic [4:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_count = v;
  endtask

  task automatic send_load(logic [3:0] s, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] q);
    pcpg_pkg::in_beat_t b;
    b.func = pcpg_pkg::FUNC_LOAD;
    b.slot = s;
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.charge_strength = q;
    send_beat(b);
  endtask

  // The slot and strength fields of an evaluate beat carry noise.
  task automatic send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pcpg_pkg::in_beat_t b;
    b.func = pcpg_pkg::FUNC_EVAL;
    b.slot = 4'($urandom);
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.charge_strength = $urandom;
    send_beat(b);
  endtask

  // Coordinates: mostly near the origin where the fields are interesting,
  // sometimes across the full range, sometimes at the extremes, zero or minus one.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      5, 6, 7: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_strength();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
    endcase
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] v);
    return v + 32'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16);
  endfunction

  task automatic random_beat();
    int s, n;
    n = (cur_count > 16) ? 16 : int'(cur_count);
    if ($urandom_range(0, 1) == 0) begin
      send_load(4'($urandom_range(0, 15)), pick_coord(), pick_coord(), pick_coord(),
                pick_strength());
    end else begin
      s = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 7))
        // Exactly on an active charge, so the singular path is taken unless the count is zero.
        0: send_eval(aim_x[s], aim_y[s], aim_z[s]);
        1, 2, 3: send_eval(nudge(aim_x[s]), nudge(aim_y[s]), nudge(aim_z[s]));
        default: send_eval(pick_coord(), pick_coord(), pick_coord());
      endcase
    end
  endtask

  initial begin
    logic [4:0] phase_counts [12];
    int         phase_len;
    phase_counts = '{5'd1, 5'd2, 5'd0, 5'd3, 5'd1, 5'd16, 5'd2, 5'd4, 5'd31, 5'd1, 5'd2, 5'd1};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: fill every slot before anything is evaluated. Slot 0
    // holds the largest strength, slot 1 the most negative, slot 2 none.
    send_load(4'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_load(4'd1, 32'hFFFF_0000, 32'h0002_0000, 32'h0, 32'h8000_0000);
    send_load(4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_load(4'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
    for (int i = 4; i < 16; i++)
      send_load(4'(i), pick_coord(), pick_coord(), pick_coord(), pick_strength());

    // At the reset count of twelve: on a positive charge, on a negative
    // charge, one step of resolution from a charge at each far corner, and the origin.
    send_eval(32'h0001_0000, 32'h0, 32'h0);
    send_eval(32'hFFFF_0000, 32'h0002_0000, 32'h0);
    send_eval(32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    send_eval(32'h0, 32'h0, 32'h0);

    // Random part in phases of differing charge count. Large counts make an
    // evaluation slow, so those phases stay short.
    for (int p = 0; p < 12; p++) begin
      set_charge_count(phase_counts[p]);
      if (p == 11) idling_on = 1'b0;
      phase_len = (phase_counts[p] >= 8) ? 12 : ((phase_counts[p] >= 4) ? 60 : 120);
      for (int k = 0; k < phase_len; k++) begin
        if (p == 3 && k == 50) drain_results();
        random_beat();
      end
    end

    drain_results();
    $display("Sent %0d beats (%0d evaluations) over twelve charge-count settings,", beats_sent,
             eval_sent);
    $display("including empty, full and over-range tables; %0d results checked.", results_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
